// ===== rtl/core/crli_pkg.sv =====
// Package with shared types, constants and the LED index table of the circle rasterizer.
`timescale 1ns / 1ps

package crli_pkg;

  // Default geometry of the LED matrix and the radius limit.
  localparam int CRLI_MATRIX_WIDTH  = 8;
  localparam int CRLI_MATRIX_HEIGHT = 8;
  localparam int CRLI_MAX_RADIUS    = 8;

  // Field widths of the channel words.
  localparam int CRLI_COORD_W  = 3;
  localparam int CRLI_RADIUS_W = 4;
  localparam int CRLI_COLOR_W  = 24;
  localparam int CRLI_INDEX_W  = 6;

  // Reset value of the hidden index register.
  localparam logic [CRLI_INDEX_W-1:0] CRLI_HIDDEN_RESET = 6'd46;

  // Number of entries in the LED index table.
  localparam int CRLI_TABLE_SIZE = 64;

  // Index of the last iteration; the rasterizer stops after at most sixteen iterations.
  localparam logic [3:0] CRLI_LAST_ITER = 4'd15;

  // Octant counter codes, in emission order.
  localparam logic [1:0] CRLI_OCT_LEFT  = 2'd0;
  localparam logic [1:0] CRLI_OCT_RIGHT = 2'd1;
  localparam logic [1:0] CRLI_OCT_DOWN  = 2'd2;
  localparam logic [1:0] CRLI_OCT_UP    = 2'd3;

  // Controller states.
  typedef enum logic {
    CRLI_IDLE,
    CRLI_DRAW
  } crli_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new circle word
    logic emit;   // produce one pixel write and step the rasterizer
  } crli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;   // the output register can take a word this cycle
    logic last_write;  // the pending write closes the circle
  } crli_sts_t;

  // LED index table, row-major over the 8x8 matrix.
  localparam logic [CRLI_INDEX_W-1:0] CRLI_LED_MAP [CRLI_TABLE_SIZE] = '{
    6'd0,  6'd8,  6'd46, 6'd51, 6'd55, 6'd59, 6'd30, 6'd38,
    6'd1,  6'd9,  6'd16, 6'd52, 6'd56, 6'd27, 6'd31, 6'd39,
    6'd2,  6'd10, 6'd17, 6'd19, 6'd23, 6'd28, 6'd32, 6'd40,
    6'd3,  6'd11, 6'd18, 6'd20, 6'd24, 6'd29, 6'd33, 6'd41,
    6'd4,  6'd12, 6'd47, 6'd21, 6'd25, 6'd60, 6'd34, 6'd42,
    6'd5,  6'd13, 6'd48, 6'd22, 6'd26, 6'd61, 6'd35, 6'd43,
    6'd6,  6'd14, 6'd49, 6'd53, 6'd57, 6'd62, 6'd36, 6'd44,
    6'd7,  6'd15, 6'd50, 6'd54, 6'd58, 6'd63, 6'd37, 6'd45
  };

endpackage

// ===== rtl/core/crli_if.sv =====
// Valid/ready channel interfaces for circle requests and LED writes.
`timescale 1ns / 1ps

// Channel that carries one circle request per word.
interface crli_in_if;
  logic                                valid;
  logic                                ready;
  logic [crli_pkg::CRLI_COORD_W-1:0]   center_x;
  logic [crli_pkg::CRLI_COORD_W-1:0]   center_y;
  logic [crli_pkg::CRLI_RADIUS_W-1:0]  radius;
  logic [crli_pkg::CRLI_COLOR_W-1:0]   color;

  modport source (output valid, center_x, center_y, radius, color, input ready);
  modport sink   (input valid, center_x, center_y, radius, color, output ready);
endinterface

// Channel that carries one LED write per word.
interface crli_out_if;
  logic                                valid;
  logic                                ready;
  logic [crli_pkg::CRLI_INDEX_W-1:0]   led_index;
  logic [crli_pkg::CRLI_COLOR_W-1:0]   pixel_color;
  logic                                last;

  modport source (output valid, led_index, pixel_color, last, input ready);
  modport sink   (input valid, led_index, pixel_color, last, output ready);
endinterface

// ===== rtl/core/crli_ctrl.sv =====
// Controller state machine that sequences the pixel writes of one circle.
`timescale 1ns / 1ps

module crli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crli_pkg::crli_sts_t sts,
  output crli_pkg::crli_cmd_t cmd
);

  crli_pkg::crli_state_t state_r;
  crli_pkg::crli_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crli_pkg::CRLI_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a circle starts on an accepted word and ends with its last write.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crli_pkg::CRLI_IDLE: begin
        if (in_valid) begin
          state_nxt = crli_pkg::CRLI_DRAW;
        end
      end
      crli_pkg::CRLI_DRAW: begin
        if (sts.slot_free && sts.last_write) begin
          state_nxt = crli_pkg::CRLI_IDLE;
        end
      end
      default: begin
        state_nxt = crli_pkg::CRLI_IDLE;
      end
    endcase
  end

  // Outputs: accept in idle, emit one write whenever the output register has room.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      crli_pkg::CRLI_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      crli_pkg::CRLI_DRAW: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/crli_datapath.sv =====
// Datapath with the rasterizer registers, the index mapping and the output register.
`timescale 1ns / 1ps

module crli_datapath #(
  parameter int MATRIX_WIDTH  = crli_pkg::CRLI_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = crli_pkg::CRLI_MATRIX_HEIGHT,
  parameter int MAX_RADIUS    = crli_pkg::CRLI_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [crli_pkg::CRLI_COORD_W-1:0]   in_center_x,
  input  logic [crli_pkg::CRLI_COORD_W-1:0]   in_center_y,
  input  logic [crli_pkg::CRLI_RADIUS_W-1:0]  in_radius,
  input  logic [crli_pkg::CRLI_COLOR_W-1:0]   in_color,
  input  logic                                cfg_wr_en,
  input  logic [crli_pkg::CRLI_INDEX_W-1:0]   cfg_wr_data,
  input  crli_pkg::crli_cmd_t                 cmd,
  output crli_pkg::crli_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crli_pkg::CRLI_INDEX_W-1:0]   out_led_index,
  output logic [crli_pkg::CRLI_COLOR_W-1:0]   out_pixel_color,
  output logic                                out_last
);

  // Held operands and rasterizer variables.
  logic [crli_pkg::CRLI_COORD_W-1:0] cx_r;
  logic [crli_pkg::CRLI_COORD_W-1:0] cy_r;
  logic [crli_pkg::CRLI_COLOR_W-1:0] color_r;
  logic signed [4:0]                 x_r;
  logic signed [4:0]                 y_r;
  logic signed [7:0]                 e_r;
  logic [1:0]                        oct_r;
  logic [3:0]                        iter_r;
  logic [crli_pkg::CRLI_INDEX_W-1:0] hidden_r;

  // Output register.
  logic                              out_valid_r;
  logic [crli_pkg::CRLI_INDEX_W-1:0] out_idx_r;
  logic [crli_pkg::CRLI_COLOR_W-1:0] out_color_r;
  logic                              out_last_r;

  // Load values for a new circle.
  logic [crli_pkg::CRLI_RADIUS_W-1:0] r_sat;
  logic signed [4:0]                  x_load;
  logic signed [7:0]                  e_load;

  // Rasterizer step.
  logic signed [7:0] x8;
  logic signed [7:0] y8;
  logic signed [7:0] y1;
  logic signed [7:0] e1;
  logic signed [7:0] x1;
  logic signed [7:0] e2;
  logic              more_iter;

  // Pixel coordinate and its mapping.
  logic signed [5:0] cx6;
  logic signed [5:0] cy6;
  logic signed [5:0] xs6;
  logic signed [5:0] ys6;
  logic signed [5:0] col;
  logic signed [5:0] row;
  logic              on_matrix;
  logic [8:0]        pos;
  logic [crli_pkg::CRLI_INDEX_W-1:0] led_idx;

  // Saturate the radius and form the starting x and error.
  always_comb begin
    if (in_radius > crli_pkg::CRLI_RADIUS_W'(MAX_RADIUS)) begin
      r_sat = crli_pkg::CRLI_RADIUS_W'(MAX_RADIUS);
    end else begin
      r_sat = in_radius;
    end
    x_load = -$signed({1'b0, r_sat});
    e_load = 8'sd2 - $signed({3'b000, r_sat, 1'b0});
  end

  // One iteration of the error-term update, taken after the fourth octant.
  always_comb begin
    x8 = {{3{x_r[4]}}, x_r};
    y8 = {{3{y_r[4]}}, y_r};
    if (e_r <= y8) begin
      y1 = y8 + 8'sd1;
      e1 = e_r + (y1 <<< 1) + 8'sd1;
    end else begin
      y1 = y8;
      e1 = e_r;
    end
    if ((e_r > x8) || (e1 > y1)) begin
      x1 = x8 + 8'sd1;
      e2 = e1 + (x1 <<< 1) + 8'sd1;
    end else begin
      x1 = x8;
      e2 = e1;
    end
    more_iter = x1[7] && (iter_r != crli_pkg::CRLI_LAST_ITER);
  end

  // Coordinate of the pending write, by octant.
  always_comb begin
    cx6 = $signed({3'b000, cx_r});
    cy6 = $signed({3'b000, cy_r});
    xs6 = {x_r[4], x_r};
    ys6 = {y_r[4], y_r};
    case (oct_r)
      crli_pkg::CRLI_OCT_LEFT: begin
        col = cx6 + xs6;
        row = cy6 - ys6;
      end
      crli_pkg::CRLI_OCT_RIGHT: begin
        col = cx6 - xs6;
        row = cy6 + ys6;
      end
      crli_pkg::CRLI_OCT_DOWN: begin
        col = cx6 + ys6;
        row = cy6 + xs6;
      end
      crli_pkg::CRLI_OCT_UP: begin
        col = cx6 - ys6;
        row = cy6 - xs6;
      end
      default: begin
        col = cx6;
        row = cy6;
      end
    endcase
  end

  // Map the coordinate through the LED table; off-matrix writes take the hidden index.
  always_comb begin
    on_matrix = !col[5] && !row[5] &&
                (col < 6'(MATRIX_WIDTH)) && (row < 6'(MATRIX_HEIGHT));
    pos = 9'(row[3:0]) * 9'(MATRIX_WIDTH) + 9'(col[3:0]);
    if (on_matrix && (pos < 9'(crli_pkg::CRLI_TABLE_SIZE))) begin
      led_idx = crli_pkg::CRLI_LED_MAP[pos[5:0]];
    end else begin
      led_idx = hidden_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.slot_free  = !out_valid_r || out_ready;
    sts.last_write = (oct_r == crli_pkg::CRLI_OCT_UP) && !more_iter;
  end

  // Hidden index configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidden_r <= crli_pkg::CRLI_HIDDEN_RESET;
    end else if (cfg_wr_en) begin
      hidden_r <= cfg_wr_data;
    end
  end

  // Rasterizer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      color_r <= '0;
      x_r     <= '0;
      y_r     <= '0;
      e_r     <= '0;
      oct_r   <= crli_pkg::CRLI_OCT_LEFT;
      iter_r  <= '0;
    end else if (cmd.load) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      color_r <= in_color;
      x_r     <= x_load;
      y_r     <= '0;
      e_r     <= e_load;
      oct_r   <= crli_pkg::CRLI_OCT_LEFT;
      iter_r  <= '0;
    end else if (cmd.emit) begin
      oct_r <= oct_r + 2'd1;
      if (oct_r == crli_pkg::CRLI_OCT_UP) begin
        x_r    <= x1[4:0];
        y_r    <= y1[4:0];
        e_r    <= e2;
        iter_r <= iter_r + 4'd1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r   <= led_idx;
      out_color_r <= color_r;
      out_last_r  <= sts.last_write;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_index   = out_idx_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/circle_raster_to_led_index_top.sv =====
// Top level of the circle rasterizer that emits LED index writes.
`timescale 1ns / 1ps

// Each request word draws a circle of the given center, radius and color with the
// integer error-term midpoint algorithm and emits one LED write word per pixel,
// four per rasterizer iteration, with last set on the final word. Pixels off the
// matrix map to the hidden index written through cfg_wr_en/cfg_wr_data. A circle
// takes N rasterizer iterations, where N is 1 for radius zero and at most 16; the
// write rate is set by the single output register, which takes one write per cycle
// while the output is ready. A new request is taken in the cycle after the last
// write of the previous one enters the output register.
module circle_raster_to_led_index_top #(
  parameter int MATRIX_WIDTH  = crli_pkg::CRLI_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = crli_pkg::CRLI_MATRIX_HEIGHT,
  parameter int MAX_RADIUS    = crli_pkg::CRLI_MAX_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  crli_in_if.sink                           in_ch,
  crli_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [crli_pkg::CRLI_INDEX_W-1:0] cfg_wr_data
);

  crli_pkg::crli_cmd_t cmd;
  crli_pkg::crli_sts_t sts;

  // Sequencer.
  crli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Rasterizer, index mapping and output register.
  crli_datapath #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT),
    .MAX_RADIUS    (MAX_RADIUS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_center_x     (in_ch.center_x),
    .in_center_y     (in_ch.center_y),
    .in_radius       (in_ch.radius),
    .in_color        (in_ch.color),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_led_index   (out_ch.led_index),
    .out_pixel_color (out_ch.pixel_color),
    .out_last        (out_ch.last)
  );

endmodule

// ===== rtl/core/crli_checker.sv =====
// Port-level checker for the circle rasterizer and its bind to the top level.
`timescale 1ns / 1ps

module crli_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [crli_pkg::CRLI_INDEX_W-1:0] out_led_index,
  input logic [crli_pkg::CRLI_COLOR_W-1:0] out_pixel_color,
  input logic                              out_last
);

  // A stalled write word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_index) &&
      $stable(out_pixel_color) && $stable(out_last))
    else $error("write word changed while stalled");

  // One circle at a time: no new request right after one is taken.
  a_one_circle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a circle is in progress");

  // While a write that is not the last is shown, the circle is still drawing.
  a_busy_mid_circle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request port open in the middle of a circle");

  // Reset leaves no write word pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("write word pending after reset");

endmodule

bind circle_raster_to_led_index_top crli_checker u_crli_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_led_index   (out_ch.led_index),
  .out_pixel_color (out_ch.pixel_color),
  .out_last        (out_ch.last)
);

// ===== tb/circle_raster_to_led_index_top_test.sv =====
// Self-checking testbench for the circle rasterizer that maps pixel writes to LED indexes.
`timescale 1ns / 1ps

module circle_raster_to_led_index_top_test;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int MAX_WRITES_PER_CIRCLE = 64;
  localparam int MAX_ITERATIONS = 16;

  // LED position of every matrix cell, row-major.
  localparam logic [crli_pkg::CRLI_INDEX_W-1:0] LED_OF_CELL [crli_pkg::CRLI_TABLE_SIZE] = '{
    6'd0,  6'd8,  6'd46, 6'd51, 6'd55, 6'd59, 6'd30, 6'd38,
    6'd1,  6'd9,  6'd16, 6'd52, 6'd56, 6'd27, 6'd31, 6'd39,
    6'd2,  6'd10, 6'd17, 6'd19, 6'd23, 6'd28, 6'd32, 6'd40,
    6'd3,  6'd11, 6'd18, 6'd20, 6'd24, 6'd29, 6'd33, 6'd41,
    6'd4,  6'd12, 6'd47, 6'd21, 6'd25, 6'd60, 6'd34, 6'd42,
    6'd5,  6'd13, 6'd48, 6'd22, 6'd26, 6'd61, 6'd35, 6'd43,
    6'd6,  6'd14, 6'd49, 6'd53, 6'd57, 6'd62, 6'd36, 6'd44,
    6'd7,  6'd15, 6'd50, 6'd54, 6'd58, 6'd63, 6'd37, 6'd45
  };

  typedef struct {
    logic [crli_pkg::CRLI_COORD_W-1:0]  center_x;
    logic [crli_pkg::CRLI_COORD_W-1:0]  center_y;
    logic [crli_pkg::CRLI_RADIUS_W-1:0] radius;
    logic [crli_pkg::CRLI_COLOR_W-1:0]  color;
  } circle_req_t;

  typedef struct {
    logic [crli_pkg::CRLI_INDEX_W-1:0] led_index;
    logic [crli_pkg::CRLI_COLOR_W-1:0] pixel_color;
    logic                              last;
  } led_write_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [crli_pkg::CRLI_INDEX_W-1:0] cfg_wr_data;

  crli_in_if  in_ch ();
  crli_out_if out_ch ();

  circle_raster_to_led_index_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  circle_req_t circle_requests[$];
  circle_req_t req_on_bus;
  led_write_t  led_writes_due[$];
  logic [crli_pkg::CRLI_INDEX_W-1:0] hidden_led_model;
  logic in_taken;
  logic steady_flow;
  int   in_gap;
  int   out_stall;
  int   idle_cycles;
  int   mismatch_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $realtime, what);
  endtask

  // Length of the next idle stretch: zero in steady flow, else mostly short, now and then long.
  function automatic int next_gap();
    if (steady_flow) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(8, 40);
  endfunction

  // LED index for one pixel; anything off the matrix goes to the hidden index.
  function automatic logic [crli_pkg::CRLI_INDEX_W-1:0] led_for_pixel(input int col,
                                                                      input int row);
    int slot;
    if (col < 0 || row < 0 || col >= crli_pkg::CRLI_MATRIX_WIDTH ||
        row >= crli_pkg::CRLI_MATRIX_HEIGHT)
      return hidden_led_model;
    slot = row * crli_pkg::CRLI_MATRIX_WIDTH + col;
    if (slot >= crli_pkg::CRLI_TABLE_SIZE) return hidden_led_model;
    return LED_OF_CELL[6'(slot)];
  endfunction

  // Rasterize one circle and queue the LED writes it must produce.
  function automatic void predict_circle_writes(input circle_req_t req);
    led_write_t circle_writes[$];
    led_write_t wr;
    int cx, cy, r, x, y, err, prev, iter;
    int cols[4];
    int rows[4];
    cx = req.center_x;
    cy = req.center_y;
    r = (req.radius > crli_pkg::CRLI_MAX_RADIUS) ? crli_pkg::CRLI_MAX_RADIUS : req.radius;
    x = -r;
    y = 0;
    err = 2 - 2 * r;
    iter = 0;
    do begin
      cols = '{cx + x, cx - x, cx + y, cx - y};
      rows = '{cy - y, cy + y, cy + x, cy - x};
      for (int k = 0; k < 4; k++) begin
        if (circle_writes.size() < MAX_WRITES_PER_CIRCLE) begin
          wr.led_index = led_for_pixel(cols[k], rows[k]);
          wr.pixel_color = req.color;
          wr.last = 1'b0;
          circle_writes.push_back(wr);
        end
      end
      prev = err;
      if (prev <= y) begin
        y++;
        err += 2 * y + 1;
      end
      if (prev > x || err > y) begin
        x++;
        err += 2 * x + 1;
      end
      iter++;
    end while (x < 0 && iter < MAX_ITERATIONS);
    circle_writes[circle_writes.size() - 1].last = 1'b1;
    foreach (circle_writes[i]) led_writes_due.push_back(circle_writes[i]);
  endfunction

  task automatic queue_circle(input int cx, input int cy, input int r, input int color);
    circle_req_t req;
    req.center_x = crli_pkg::CRLI_COORD_W'(cx);
    req.center_y = crli_pkg::CRLI_COORD_W'(cy);
    req.radius = crli_pkg::CRLI_RADIUS_W'(r);
    req.color = crli_pkg::CRLI_COLOR_W'(color);
    circle_requests.push_back(req);
  endtask

  // Wait until every queued circle has been taken and all its writes have come out.
  task automatic wait_idle();
    while (circle_requests.size() != 0 || in_ch.valid || led_writes_due.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_hidden_index(input logic [crli_pkg::CRLI_INDEX_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hidden_led_model = value;
  endtask

  // Request driver: holds a word until it is taken, then idles for a random gap.
  always @(negedge clk) begin
    circle_req_t req;
    logic send;
    req = req_on_bus;
    send = 1'b0;
    if (!rst_n) begin
      send = 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      send = 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
    end else if (circle_requests.size() > 0) begin
      req = circle_requests.pop_front();
      send = 1'b1;
      in_gap = next_gap();
    end
    req_on_bus <= req;
    in_ch.valid <= send;
    in_ch.center_x <= req.center_x;
    in_ch.center_y <= req.center_y;
    in_ch.radius <= req.radius;
    in_ch.color <= req.color;
  end

  // Output backpressure: random stalls of mixed length.
  always @(negedge clk) begin
    logic rdy;
    if (out_stall > 0) begin
      out_stall--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 20) out_stall = next_gap();
    end
    out_ch.ready <= rdy;
  end

  // Monitor: predict on each taken request, check each LED write, watch for hangs.
  always @(posedge clk) begin
    led_write_t want;
    logic moved;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        predict_circle_writes('{in_ch.center_x, in_ch.center_y, in_ch.radius, in_ch.color});
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (led_writes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected write led_index=%0d color=%06h last=%0b",
                                    out_ch.led_index, out_ch.pixel_color, out_ch.last));
        end else begin
          want = led_writes_due.pop_front();
          if (out_ch.led_index !== want.led_index)
            report_mismatch($sformatf("led_index %0d, expected %0d",
                                      out_ch.led_index, want.led_index));
          if (out_ch.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color %06h, expected %06h",
                                      out_ch.pixel_color, want.pixel_color));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, want.last));
        end
      end
      if (moved || (circle_requests.size() == 0 && !in_ch.valid && led_writes_due.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("circle_raster_to_led_index_top verification failed");
        $finish;
      end
    end
  end

  // Stimulus: directed circles, then random phases under several hidden index settings.
  initial begin
    logic [crli_pkg::CRLI_INDEX_W-1:0] hidden_settings[5];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius = '0;
    in_ch.color = '0;
    out_ch.ready = 1'b0;
    req_on_bus = '{'0, '0, '0, '0};
    hidden_led_model = crli_pkg::CRLI_HIDDEN_RESET;
    steady_flow = 1'b0;
    in_gap = 0;
    out_stall = 0;
    idle_cycles = 0;
    mismatch_count = 0;
    hidden_settings = '{6'd0, 6'd63, 6'($urandom), 6'($urandom), 6'($urandom)};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: center-only circles, every radius, saturated radii, off-matrix edges.
    queue_circle(0, 0, 0, 24'h000000);
    queue_circle(7, 7, 0, 24'hFFFFFF);
    queue_circle(3, 4, 1, 24'hAAAAAA);
    queue_circle(3, 3, 2, 24'h555555);
    queue_circle(4, 4, 3, 24'h123456);
    queue_circle(0, 7, 4, 24'hFEDCBA);
    queue_circle(7, 0, 5, 24'h0F0F0F);
    queue_circle(2, 5, 6, 24'hF0F0F0);
    queue_circle(5, 2, 7, 24'h800001);
    queue_circle(3, 4, 8, 24'hFFFFFF);
    queue_circle(0, 0, 8, 24'h000000);
    queue_circle(7, 7, 8, 24'h7FFFFE);
    queue_circle(4, 3, 9, 24'hC3C3C3);
    queue_circle(1, 6, 12, 24'h3C3C3C);
    queue_circle(6, 1, 15, 24'h00FF00);
    queue_circle(0, 3, 3, 24'hFF0000);
    queue_circle(7, 4, 3, 24'h0000FF);
    queue_circle(4, 0, 2, 24'h010203);
    queue_circle(3, 7, 2, 24'hFDFEFF);

    // Random phases, each under its own hidden index; every other one runs without idling.
    for (int phase = 0; phase < 5; phase++) begin
      write_hidden_index(hidden_settings[phase]);
      steady_flow = phase[0];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_circle($urandom_range(0, 7), $urandom_range(0, 7),
                     ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 15),
                     $urandom);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("circle_raster_to_led_index_top verification clean");
    end else begin
      $display("circle_raster_to_led_index_top verification failed");
    end
    $finish;
  end

endmodule
